[rtl/core/isk_pkg.sv]
// ----------------------------------------------------------------------------
// isk_pkg: shared definitions of the indexed stack engine
// Opcode and status codes and the fixed widths of the command and result
// fields.
// ----------------------------------------------------------------------------
`default_nettype none

package isk_pkg;

	localparam int OPCODE_W = 3;
	localparam int DEPTH_W  = 12;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_POP    = 3'd1;
	localparam opcode_t OP_DROP   = 3'd2;
	localparam opcode_t OP_PEEK   = 3'd3;
	localparam opcode_t OP_CLEAR  = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/indexed_stack_engine.sv]
// ----------------------------------------------------------------------------
// indexed_stack_engine: random-access stack of item handles
// Insert, pop, drop and peek at a depth counted from the top (negative depth
// counts from the bottom for pop, drop and peek), and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A command (opcode, depth, item_in) transfers at a rising edge with start
//   high and busy low. busy then stays high until the result is shown.
//   Each command gives one result on item_out, found, status and count,
//   valid for exactly one cycle while done is high; the receiver cannot
//   stall it. busy falls in the cycle after done, so a new command may
//   follow right away.
//   Entries live in a single memory (one write and one registered read port)
//   driven by a small sequencer. Moving one entry takes a check, a read and
//   a write step. An insert first moves every entry above the new place up
//   one place, then writes the item; a peek reads the entry; a pop reads
//   the entry and then moves the entries above it down one place; a drop
//   only moves the entries down. Clear, rejected and unused commands go
//   straight to the result.
//   Reset empties the stack at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_stack_engine #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [isk_pkg::OPCODE_W-1:0]     opcode,
	input  wire  signed [isk_pkg::DEPTH_W-1:0] depth,
	input  wire  [DATA_W-1:0]                item_in,
	output logic                             done,
	output logic [DATA_W-1:0]                item_out,
	output logic                             found,
	output logic [isk_pkg::STATUS_W-1:0]     status,
	output logic [isk_pkg::COUNT_W-1:0]      count
);
	import isk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = ((CW > DEPTH_W) ? CW : DEPTH_W) + 2;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_INS_CHK = 4'd2;
	localparam logic [3:0] S_INS_RD  = 4'd3;
	localparam logic [3:0] S_INS_WR  = 4'd4;
	localparam logic [3:0] S_PUT     = 4'd5;
	localparam logic [3:0] S_GET_RD  = 4'd6;
	localparam logic [3:0] S_GET_CAP = 4'd7;
	localparam logic [3:0] S_REM_CHK = 4'd8;
	localparam logic [3:0] S_REM_RD  = 4'd9;
	localparam logic [3:0] S_REM_WR  = 4'd10;
	localparam logic [3:0] S_FINISH  = 4'd11;

	logic [3:0]          state_q;
	logic [CW-1:0]       cnt_q;
	opcode_t             op_q;
	logic [DEPTH_W-1:0]  dep_q;
	logic [DATA_W-1:0]   item_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       ptr_q;
	logic [DATA_W-1:0]   res_item_q;
	logic                res_found_q;
	status_t             res_status_q;

	logic [DATA_W-1:0]   mem [DEPTH];
	logic [DATA_W-1:0]   rdata_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [AW-1:0]       mem_raddr;
	logic [DATA_W-1:0]   mem_wdata;

	logic signed [SW-1:0] d_s;
	logic signed [SW-1:0] cnt_s;
	logic signed [SW-1:0] dd_s;
	logic signed [SW-1:0] pos_ins_s;
	logic signed [SW-1:0] pos_get_s;
	logic                 ins_bad;
	logic                 get_bad;
	logic                 full;
	logic [CW-1:0]        rem_next;
	logic                 rem_more;

	// Range arithmetic on the latched command
	always_comb begin
		d_s       = $signed({{(SW-DEPTH_W){dep_q[DEPTH_W-1]}}, dep_q});
		cnt_s     = $signed({{(SW-CW){1'b0}}, cnt_q});
		dd_s      = d_s[SW-1] ? (d_s + cnt_s) : d_s;
		pos_ins_s = cnt_s - d_s;
		pos_get_s = cnt_s - dd_s - SW'(1);
		ins_bad   = d_s[SW-1] || (d_s > cnt_s);
		get_bad   = dd_s[SW-1] || (dd_s >= cnt_s);
		full      = (cnt_q == CW'(DEPTH));
		rem_next  = CW'(ptr_q) + CW'(1);
		rem_more  = rem_next < cnt_q;
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rdata_q;
		mem_raddr = pos_q;
		unique case (state_q)
			S_INS_RD:  mem_raddr = ptr_q - AW'(1);
			S_INS_WR:  mem_we = 1'b1;
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = item_q;
			end
			S_REM_RD:  mem_raddr = ptr_q + AW'(1);
			S_REM_WR:  mem_we = 1'b1;
			default:   mem_raddr = pos_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			op_q         <= OP_INSERT;
			dep_q        <= '0;
			item_q       <= '0;
			pos_q        <= '0;
			ptr_q        <= '0;
			res_item_q   <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						dep_q   <= depth;
						item_q  <= item_in;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_item_q   <= '0;
					res_found_q  <= 1'b0;
					res_status_q <= ST_OK;
					state_q      <= S_FINISH;
					case (op_q) inside
						OP_INSERT: begin
							if (ins_bad) begin
								res_status_q <= ST_RANGE;
							end else if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								pos_q   <= pos_ins_s[AW-1:0];
								ptr_q   <= cnt_q[AW-1:0];
								state_q <= S_INS_CHK;
							end
						end
						OP_POP, OP_PEEK: begin
							if (get_bad) begin
								res_status_q <= ST_RANGE;
							end else begin
								pos_q   <= pos_get_s[AW-1:0];
								state_q <= S_GET_RD;
							end
						end
						OP_DROP: begin
							if (get_bad) begin
								res_status_q <= ST_RANGE;
							end else begin
								ptr_q   <= pos_get_s[AW-1:0];
								state_q <= S_REM_CHK;
							end
						end
						OP_CLEAR: cnt_q <= '0;
						default: ;
					endcase
				end
				// open a hole at pos_q by moving entries up one place
				S_INS_CHK: state_q <= (ptr_q > pos_q) ? S_INS_RD : S_PUT;
				S_INS_RD:  state_q <= S_INS_WR;
				S_INS_WR: begin
					ptr_q   <= ptr_q - AW'(1);
					state_q <= S_INS_CHK;
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_GET_RD:  state_q <= S_GET_CAP;
				S_GET_CAP: begin
					res_item_q  <= rdata_q;
					res_found_q <= 1'b1;
					ptr_q       <= pos_q;
					state_q     <= (op_q == OP_PEEK) ? S_FINISH : S_REM_CHK;
				end
				// close the gap by moving entries above it down one place
				S_REM_CHK: begin
					if (rem_more) begin
						state_q <= S_REM_RD;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_REM_RD:  state_q <= S_REM_WR;
				S_REM_WR: begin
					ptr_q   <= ptr_q + AW'(1);
					state_q <= S_REM_CHK;
				end
				S_FINISH:  state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_FINISH);
	assign item_out = res_item_q;
	assign found    = res_found_q;
	assign status   = res_status_q;
	assign count    = COUNT_W'(cnt_q);

endmodule

`default_nettype wire

[rtl/core/isk_checker.sv]
// ----------------------------------------------------------------------------
// isk_checker: port-level checks of the indexed stack engine
// Watches the command and result ports over time; bound into every engine instance.
// ----------------------------------------------------------------------------
`default_nettype none

module isk_checker #(
	parameter int DATA_W = 32
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              start,
	input wire                              busy,
	input wire                              done,
	input wire [DATA_W-1:0]                 item_out,
	input wire                              found,
	input wire [isk_pkg::STATUS_W-1:0]      status
);
	import isk_pkg::*;

	// a transferred command keeps the engine busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not raise busy");

	// the result is shown while the engine is still busy, then it frees up
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("result not framed by busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found with a failing status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> item_out == '0)
		else $error("item_out not zero without a hit");

endmodule

bind indexed_stack_engine isk_checker #(.DATA_W(DATA_W)) u_isk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.item_out (item_out),
	.found    (found),
	.status   (status)
);

`default_nettype wire

[verif/indexed_stack_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_stack_engine_tb: self-checking bench of the indexed stack engine
// Drives insert, pop, drop, peek, clear and unused commands, directed first
// and then random, and tracks a shadow stack that predicts every result.
// The stack is filled to capacity once to cover the full and deep-shift cases.
// ----------------------------------------------------------------------------

module indexed_stack_engine_tb;
	import isk_pkg::*;

	localparam int STACK_DEPTH  = 1024;
	localparam int ITEM_W       = 32;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RAND_ITEMS   = 140;

	class stack_scoreboard #(int SLOTS = 1024, int W = 32);
		typedef struct packed {
			logic [W-1:0]       item;
			logic               hit;
			status_t            st;
			logic [COUNT_W-1:0] cnt;
		} outcome_t;

		logic [W-1:0] slots [SLOTS];
		int           fill;
		int           errors;
		outcome_t     outstanding [$];

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 100) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
			errors++;
		endtask

		// Apply one accepted command to the shadow stack and queue its outcome.
		function void apply_command(opcode_t op, logic signed [DEPTH_W-1:0] dv,
		                            logic [W-1:0] item);
			outcome_t o;
			int       d;
			int       pos;
			int       x;
			o = '0;
			o.st = ST_OK;
			d = dv;
			case (op)
				OP_INSERT: begin
					if (d < 0 || d > fill) begin
						o.st = ST_RANGE;
					end else if (fill >= SLOTS) begin
						o.st = ST_FULL;
					end else begin
						pos = fill - d;
						for (x = fill; x > pos; x--) slots[x] = slots[x-1];
						slots[pos] = item;
						fill++;
					end
				end
				OP_POP, OP_DROP, OP_PEEK: begin
					// negative depth counts from the bottom
					if (d < 0) d += fill;
					if (d < 0 || d >= fill) begin
						o.st = ST_RANGE;
					end else begin
						pos = fill - d - 1;
						if (op != OP_DROP) begin
							o.item = slots[pos];
							o.hit  = 1'b1;
						end
						if (op != OP_PEEK) begin
							for (x = pos; x < fill - 1; x++) slots[x] = slots[x+1];
							fill--;
						end
					end
				end
				OP_CLEAR: fill = 0;
				default: ;
			endcase
			o.cnt = COUNT_W'(fill);
			outstanding.push_back(o);
		endfunction

		task match_result(logic [W-1:0] item, logic hit, status_t st,
		                  logic [COUNT_W-1:0] cnt);
			outcome_t want;
			if (outstanding.size() == 0) begin
				report($sformatf("unexpected result item_out %h status %0d count %0d",
				                 item, st, cnt));
				return;
			end
			want = outstanding.pop_front();
			if (item !== want.item)
				report($sformatf("item_out %h, want %h", item, want.item));
			if (hit !== want.hit)
				report($sformatf("found %b, want %b", hit, want.hit));
			if (st !== want.st)
				report($sformatf("status %0d, want %0d", st, want.st));
			if (cnt !== want.cnt)
				report($sformatf("count %0d, want %0d", cnt, want.cnt));
		endtask
	endclass

	typedef stack_scoreboard #(.SLOTS(STACK_DEPTH), .W(ITEM_W)) scoreboard_t;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 start   = 1'b0;
	opcode_t              opcode  = OP_INSERT;
	logic [DEPTH_W-1:0]   depth   = '0;
	logic [ITEM_W-1:0]    item_in = '0;
	logic                 busy;
	logic                 done;
	logic [ITEM_W-1:0]    item_out;
	logic                 found;
	status_t              status;
	logic [COUNT_W-1:0]   count;

	int                   idle_pct    = 0;
	int unsigned          cycle_count = 0;

	scoreboard_t          sb = new();

	indexed_stack_engine #(
		.DEPTH  (STACK_DEPTH),
		.DATA_W (ITEM_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.depth    (depth),
		.item_in  (item_in),
		.done     (done),
		.item_out (item_out),
		.found    (found),
		.status   (status),
		.count    (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("indexed_stack_engine verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			sb.match_result(item_out, found, status, count);
		end
	end

	// Hold off at random, then present one command until it transfers.
	task automatic issue(opcode_t op, int d, logic [ITEM_W-1:0] item);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start   <= 1'b1;
		opcode  <= op;
		depth   <= d[DEPTH_W-1:0];
		item_in <= item;
		do @(posedge clk); while (busy !== 1'b0);
		sb.apply_command(op, d[DEPTH_W-1:0], item);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.outstanding.size() != 0);
	endtask

	task automatic rand_cmd();
		int      sel;
		int      cnt;
		int      r;
		int      d;
		opcode_t op;
		cnt = sb.fill;
		sel = (cnt > 40) ? $urandom_range(30, 99) : $urandom_range(99);
		r   = $urandom_range(9);
		if (sel < 35) begin
			op = OP_INSERT;
			if (r == 0)
				d = -int'($urandom_range(1, 1024));
			else if (r == 1)
				d = cnt + int'($urandom_range(1, 1024 - cnt));
			else
				d = $urandom_range(0, cnt);
		end else if (sel < 88) begin
			op = (sel < 55) ? OP_POP : (sel < 67) ? OP_DROP :
			     (sel < 85) ? OP_PEEK : OP_CLEAR;
			if (r < 6 && cnt > 0)
				d = $urandom_range(0, cnt - 1);
			else if (r < 8 && cnt > 0)
				d = -int'($urandom_range(1, cnt));
			else
				d = int'($urandom_range(2048)) - 1024;
		end else if (sel < 90) begin
			op = opcode_t'($urandom_range(5, 7));
			d  = int'($urandom_range(2048)) - 1024;
		end else begin
			op = opcode_t'($urandom_range(7));
			d  = int'($urandom_range(2048)) - 1024;
		end
		issue(op, d, $urandom);
	endtask

	// Fill to capacity, then hit the full cases and the longest shifts.
	task automatic fill_to_capacity();
		while (sb.fill < STACK_DEPTH) begin
			if (sb.fill > 0 && $urandom_range(19) == 0)
				issue(OP_PEEK, $urandom_range(0, sb.fill - 1), $urandom);
			else
				issue(OP_INSERT, $urandom_range(0, (sb.fill < 2) ? sb.fill : 2), $urandom);
		end
		issue(OP_INSERT, 0, $urandom);
		issue(OP_INSERT, STACK_DEPTH, $urandom);
		issue(OP_INSERT, -1, $urandom);
		issue(OP_PEEK, -STACK_DEPTH, $urandom);
		issue(OP_PEEK, STACK_DEPTH - 1, $urandom);
		issue(OP_POP, -1, $urandom);
		issue(OP_INSERT, sb.fill, $urandom);
		issue(OP_DROP, STACK_DEPTH - 1, $urandom);
		issue(OP_PEEK, STACK_DEPTH, $urandom);
		issue(OP_CLEAR, 0, $urandom);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack and bad insert depths
		issue(OP_PEEK, 0, 32'h0);
		issue(OP_POP, -1, 32'h0);
		issue(OP_DROP, 0, 32'h0);
		issue(OP_INSERT, 1, 32'hDEAD_BEEF);
		issue(OP_INSERT, -1, 32'hDEAD_BEEF);
		issue(OP_INSERT, 0, 32'hFFFF_FFFF);
		issue(OP_INSERT, 0, 32'h0000_0000);
		issue(OP_INSERT, 2, 32'hA5A5_5A5A);
		issue(OP_INSERT, 1, 32'h1234_5678);
		issue(OP_PEEK, 0, 32'h0);
		issue(OP_PEEK, -1, 32'h0);
		issue(OP_PEEK, 3, 32'h0);
		issue(OP_PEEK, 4, 32'h0);
		issue(OP_PEEK, 1024, 32'h0);
		issue(OP_PEEK, -1024, 32'h0);
		issue(OP_PEEK, -4, 32'h0);
		issue(OP_POP, 1, 32'h0);
		issue(OP_DROP, -1, 32'h0);
		issue(OP_POP, 0, 32'h0);
		issue(opcode_t'(5), 0, 32'hFFFF_FFFF);
		issue(opcode_t'(6), -1, 32'h0);
		issue(opcode_t'(7), 1024, 32'h0);
		issue(OP_INSERT, 1024, 32'h5555_AAAA);
		issue(OP_CLEAR, 0, 32'h0);
		issue(OP_POP, 0, 32'h0);

		idle_pct = 31;
		repeat (RAND_ITEMS) rand_cmd();
		drain();

		idle_pct = 47;
		repeat (RAND_ITEMS) rand_cmd();
		fill_to_capacity();
		drain();

		idle_pct = 0;
		repeat (RAND_ITEMS) rand_cmd();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding.size() == 0) begin
			$display("indexed_stack_engine verification clean");
		end else begin
			$display("indexed_stack_engine verification failed");
		end
		$finish;
	end

endmodule
